[rtl/lgtr_pkg.sv]
// Shared constants, codes and controller/datapath interface types of the topic resampler.
`default_nettype none

package lgtr_pkg;

	localparam int TOPICS     = 64;
	localparam int TOPIC_W    = $clog2(TOPICS);
	localparam int VOCAB      = 4096;
	localparam int WORD_W     = $clog2(VOCAB);
	localparam int DOC_TOKENS = 1024;
	localparam int POS_W      = $clog2(DOC_TOKENS);
	localparam int COUNT_BITS = 20;
	localparam int TEST_W     = 11;
	localparam int TOTAL_W    = 24;
	localparam int CNTV_W     = 24;
	localparam int PRIOR_W    = 24;
	localparam int VBETA_W    = 32;
	localparam int RND_W      = 32;
	localparam int FRAC_W     = 16;
	localparam int WGT_W      = 48;
	localparam int CMD_W      = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// word/topic store
	localparam int TW_W     = WORD_W + TOPIC_W;
	localparam int TW_DEPTH = VOCAB * TOPICS;

	// weight arithmetic widths
	localparam int A_W     = TEST_W + FRAC_W + 1;
	localparam int B_W     = COUNT_BITS + 1 + FRAC_W + 1;
	localparam int D_W     = TOTAL_W + 1 + FRAC_W + 1;
	localparam int P_W     = A_W + B_W;
	localparam int BLO_W   = B_W / 2;
	localparam int BHI_W   = B_W - BLO_W;
	localparam int MP_W    = A_W + BHI_W;
	localparam int NUMHI_W = P_W - WGT_W;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [TEST_W-1:0]     TEST_MAX  = '1;
	localparam logic [WGT_W-1:0]      WGT_MAX   = '1;

	localparam logic [CMD_W-1:0] CMD_LOAD_COUNT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_TOTAL = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PLACE      = 3'd2;
	localparam logic [CMD_W-1:0] CMD_RESAMPLE   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd4;
	localparam logic [CMD_W-1:0] CMD_MAJORITY   = 3'd5;

	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BETA  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VBETA = 2'd2;

	localparam logic [PRIOR_W-1:0] ALPHA_RST = 24'd32768;
	localparam logic [PRIOR_W-1:0] BETA_RST  = 24'd6554;
	localparam logic [VBETA_W-1:0] VBETA_RST = 32'd26843546;

	typedef struct packed {
		logic capture;
		logic clr_step;
		logic load_cnt;
		logic load_tot;
		logic tsel_prev;
		logic tsel_new;
		logic new_from_res;
		logic rmw_rd;
		logic rmw_wr;
		logic rmw_inc;
		logic tok_wr;
		logic fact;
		logic mul_lo;
		logic mul_hi;
		logic div_go;
		logic acc;
		logic thr_lo;
		logic thr_hi;
		logic thr_sum;
		logic srch_cmp;
		logic maj_step;
	} lgtr_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic k_last;
		logic div_done;
		logic found;
	} lgtr_stat_t;

endpackage

`default_nettype wire

[rtl/lgtr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lgtr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[rtl/lgtr_div.sv]
// Radix-2 restoring divider with 48-bit saturating quotient.
`default_nettype none

module lgtr_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [lgtr_pkg::P_W-1:0]  num,
	input  logic [lgtr_pkg::D_W-1:0]  den,
	output logic                      done,
	output logic [lgtr_pkg::WGT_W-1:0] quo
);
	import lgtr_pkg::*;

	localparam int CNT_W = $clog2(WGT_W);

	logic             run_q;
	logic             done_q;
	logic             ovf_q;
	logic [CNT_W-1:0] cnt_q;
	logic [D_W-1:0]   rem_q;
	logic [D_W-1:0]   den_q;
	logic [WGT_W-1:0] sh_q;
	logic [D_W:0]     trial;
	logic             ge;
	logic [D_W:0]     diff;
	logic             big;

	assign trial = {rem_q, sh_q[WGT_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};
	// quotient reaches 2^48 exactly when the top numerator bits alone cover the divisor
	assign big   = (den == '0) || (D_W'(num[P_W-1:WGT_W]) >= den);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			ovf_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				ovf_q <= big;
				cnt_q <= '0;
				if (big) begin
					done_q <= 1'b1;
				end else begin
					run_q <= 1'b1;
				end
			end else if (run_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(WGT_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= D_W'(num[P_W-1:WGT_W]);
			sh_q  <= num[WGT_W-1:0];
			den_q <= den;
		end else if (run_q) begin
			rem_q <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
			sh_q  <= {sh_q[WGT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = ovf_q ? WGT_MAX : sh_q;

endmodule

`default_nettype wire

[rtl/lgtr_dpath.sv]
// Datapath: count stores, weight arithmetic, threshold, topic search and majority vote.
`default_nettype none

module lgtr_dpath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lgtr_pkg::lgtr_cmd_t             cmd,
	output lgtr_pkg::lgtr_stat_t            stat,
	input  logic [lgtr_pkg::WORD_W-1:0]     word,
	input  logic [lgtr_pkg::TOPIC_W-1:0]    topic,
	input  logic [lgtr_pkg::POS_W-1:0]      position,
	input  logic [lgtr_pkg::CNTV_W-1:0]     count_value,
	input  logic [lgtr_pkg::RND_W-1:0]      random_fraction,
	input  logic                            cfg_wr,
	input  logic [lgtr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lgtr_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic [lgtr_pkg::TOPIC_W-1:0]    result_topic,
	output logic [lgtr_pkg::TOPIC_W-1:0]    previous_topic,
	output logic                            saturated
);
	import lgtr_pkg::*;

	function automatic logic [TEST_W:0] bump(input logic [TEST_W-1:0] v, input logic up);
		logic [TEST_W:0] r;
		if (up) begin
			r = (v == TEST_MAX) ? {1'b1, TEST_MAX} : {1'b0, v + TEST_W'(1)};
		end else begin
			r = (v == '0) ? {1'b1, {TEST_W{1'b0}}} : {1'b0, v - TEST_W'(1)};
		end
		return r;
	endfunction

	logic [PRIOR_W-1:0]    alpha_q, beta_q;
	logic [VBETA_W-1:0]    vbeta_q;
	logic [WORD_W-1:0]     word_q;
	logic [TOPIC_W-1:0]    topic_q, tsel_q, k_q, res_q, prev_q;
	logic [POS_W-1:0]      pos_q;
	logic [CNTV_W-1:0]     cnt_q;
	logic [RND_W-1:0]      rnd_q;
	logic                  sat_q;
	logic [TW_W-1:0]       clr_q;
	logic [TEST_W-1:0]     best_q;
	logic [A_W-1:0]        a_q;
	logic [B_W-1:0]        b_q;
	logic [D_W-1:0]        d_q;
	logic [MP_W-1:0]       plo_q, phi_q;
	logic [WGT_W-1:0]      sum_q, thr_q, thr_hi_q;
	logic [RND_W-1:0]      thr_lo_q;

	logic [TOPIC_W-1:0]    rd_idx, wr_idx, new_topic, k_next;
	logic [TEST_W-1:0]     doc_rd, tt_rd, doc_wdata, tt_wdata;
	logic [TEST_W:0]       t_b, doc_b, tt_b;
	logic [TW_W-1:0]       t_raddr, t_waddr;
	logic                  t_we;
	logic [TEST_W-1:0]     t_wdata, t_rdata;
	logic [COUNT_BITS-1:0] tr_rdata, tr_wdata;
	logic                  clip;
	logic [TOTAL_W-1:0]    tot_rdata;
	logic [TOPIC_W-1:0]    tok_rdata;
	logic [WGT_W-1:0]      cum_rdata, quo, sum_next;
	logic [WGT_W:0]        wsum;
	logic [BHI_W-1:0]      mul_b;
	logic [MP_W-1:0]       mul_p;
	logic [P_W-1:0]        num;
	logic [2*RND_W-1:0]    thr_lo_full;
	logic                  div_done;
	logic                  k_last;

	assign k_last    = (k_q == TOPIC_W'(TOPICS - 1));
	assign k_next    = k_last ? '0 : k_q + TOPIC_W'(1);
	assign rd_idx    = cmd.rmw_rd ? tsel_q : k_q;
	assign wr_idx    = cmd.clr_step ? clr_q[TOPIC_W-1:0] : tsel_q;
	assign new_topic = cmd.new_from_res ? res_q : topic_q;

	assign t_b   = bump(t_rdata, cmd.rmw_inc);
	assign doc_b = bump(doc_rd, cmd.rmw_inc);
	assign tt_b  = bump(tt_rd, cmd.rmw_inc);

	assign clip     = cnt_q > CNTV_W'(COUNT_MAX);
	assign tr_wdata = clip ? COUNT_MAX : cnt_q[COUNT_BITS-1:0];

	assign t_raddr = cmd.rmw_rd ? {word_q, tsel_q} : {word_q, k_q};
	assign t_we    = cmd.clr_step | cmd.rmw_wr;
	assign t_waddr = cmd.clr_step ? clr_q : {word_q, tsel_q};
	assign t_wdata = cmd.clr_step ? '0 : t_b[TEST_W-1:0];

	assign doc_wdata = cmd.clr_step ? '0 : doc_b[TEST_W-1:0];
	assign tt_wdata  = cmd.clr_step ? '0 : tt_b[TEST_W-1:0];

	assign mul_b = cmd.mul_hi ? b_q[B_W-1:BLO_W] : BHI_W'(b_q[BLO_W-1:0]);
	assign mul_p = MP_W'(a_q) * MP_W'(mul_b);
	assign num   = (P_W'(phi_q) << BLO_W) + P_W'(plo_q);

	assign wsum     = {1'b0, sum_q} + {1'b0, quo};
	assign sum_next = wsum[WGT_W] ? WGT_MAX : wsum[WGT_W-1:0];

	assign thr_lo_full = (2*RND_W)'(rnd_q) * (2*RND_W)'(sum_q[RND_W-1:0]);

	lgtr_ram #(.WIDTH(COUNT_BITS), .DEPTH(TW_DEPTH)) u_trained (
		.clk(clk), .we(cmd.load_cnt), .waddr({word_q, topic_q}), .wdata(tr_wdata),
		.raddr({word_q, k_q}), .rdata(tr_rdata)
	);

	lgtr_ram #(.WIDTH(TOTAL_W), .DEPTH(TOPICS)) u_totals (
		.clk(clk), .we(cmd.load_tot), .waddr(topic_q), .wdata(cnt_q),
		.raddr(k_q), .rdata(tot_rdata)
	);

	lgtr_ram #(.WIDTH(TEST_W), .DEPTH(TW_DEPTH)) u_test (
		.clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
		.raddr(t_raddr), .rdata(t_rdata)
	);

	// document counts and test totals clear with the word/topic store sweep
	lgtr_ram #(.WIDTH(TEST_W), .DEPTH(TOPICS)) u_doc (
		.clk(clk), .we(t_we), .waddr(wr_idx), .wdata(doc_wdata),
		.raddr(rd_idx), .rdata(doc_rd)
	);

	lgtr_ram #(.WIDTH(TEST_W), .DEPTH(TOPICS)) u_ttot (
		.clk(clk), .we(t_we), .waddr(wr_idx), .wdata(tt_wdata),
		.raddr(rd_idx), .rdata(tt_rd)
	);

	lgtr_ram #(.WIDTH(TOPIC_W), .DEPTH(DOC_TOKENS)) u_tokens (
		.clk(clk), .we(cmd.tok_wr), .waddr(pos_q), .wdata(new_topic),
		.raddr(pos_q), .rdata(tok_rdata)
	);

	lgtr_ram #(.WIDTH(WGT_W), .DEPTH(TOPICS)) u_cum (
		.clk(clk), .we(cmd.acc), .waddr(k_q), .wdata(sum_next),
		.raddr(k_q), .rdata(cum_rdata)
	);

	lgtr_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_go), .num(num), .den(d_q),
		.done(div_done), .quo(quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RST;
			beta_q  <= BETA_RST;
			vbeta_q <= VBETA_RST;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				CFG_ALPHA: alpha_q <= cfg_data[PRIOR_W-1:0];
				CFG_BETA:  beta_q  <= cfg_data[PRIOR_W-1:0];
				CFG_VBETA: vbeta_q <= cfg_data[VBETA_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + TW_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q  <= '0;
			prev_q <= '0;
			sat_q  <= 1'b0;
			k_q    <= '0;
			sum_q  <= '0;
			best_q <= '0;
		end else if (cmd.capture) begin
			res_q  <= '0;
			prev_q <= '0;
			sat_q  <= 1'b0;
			k_q    <= '0;
			sum_q  <= '0;
			best_q <= '0;
		end else begin
			if (cmd.load_cnt && clip) begin
				sat_q <= 1'b1;
			end
			if (cmd.rmw_wr && (t_b[TEST_W] || doc_b[TEST_W] || tt_b[TEST_W])) begin
				sat_q <= 1'b1;
			end
			if (cmd.tsel_prev) begin
				prev_q <= tok_rdata;
			end
			if (cmd.acc) begin
				sum_q <= sum_next;
				k_q   <= k_next;
			end
			if (cmd.srch_cmp) begin
				if (stat.found) begin
					res_q <= k_q;
				end else begin
					k_q <= k_next;
				end
			end
			if (cmd.maj_step) begin
				if (doc_rd > best_q) begin
					best_q <= doc_rd;
					res_q  <= k_q;
				end
				k_q <= k_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			word_q  <= word;
			topic_q <= topic;
			pos_q   <= position;
			cnt_q   <= count_value;
			rnd_q   <= random_fraction;
		end
		if (cmd.tsel_prev) begin
			tsel_q <= tok_rdata;
		end else if (cmd.tsel_new) begin
			tsel_q <= new_topic;
		end
		if (cmd.fact) begin
			a_q <= (A_W'(doc_rd) << FRAC_W) + A_W'(alpha_q);
			b_q <= ((B_W'(tr_rdata) + B_W'(t_rdata)) << FRAC_W) + B_W'(beta_q);
			d_q <= ((D_W'(tot_rdata) + D_W'(tt_rd)) << FRAC_W) + D_W'(vbeta_q);
		end
		if (cmd.mul_lo) begin
			plo_q <= mul_p;
		end
		if (cmd.mul_hi) begin
			phi_q <= mul_p;
		end
		if (cmd.thr_lo) begin
			thr_lo_q <= thr_lo_full[2*RND_W-1:RND_W];
		end
		if (cmd.thr_hi) begin
			thr_hi_q <= WGT_W'(rnd_q) * WGT_W'(sum_q[WGT_W-1:RND_W]);
		end
		if (cmd.thr_sum) begin
			thr_q <= thr_hi_q + WGT_W'(thr_lo_q);
		end
	end

	assign stat.clr_last = (clr_q == TW_W'(TW_DEPTH - 1));
	assign stat.k_last   = k_last;
	assign stat.div_done = div_done;
	// past the last topic without a hit, the last topic stands
	assign stat.found    = (cum_rdata >= thr_q) || k_last;

	assign result_topic   = res_q;
	assign previous_topic = prev_q;
	assign saturated      = sat_q;

endmodule

`default_nettype wire

[rtl/lgtr_ctrl.sv]
// Controller state machine sequencing each command through the datapath.
`default_nettype none

module lgtr_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [lgtr_pkg::CMD_W-1:0]  command,
	input  lgtr_pkg::lgtr_stat_t        stat,
	output lgtr_pkg::lgtr_cmd_t         cmd,
	output logic                        busy,
	output logic                        done
);
	import lgtr_pkg::*;

	localparam int ST_W = 23;

	typedef enum logic [ST_W-1:0] {
		S_IDLE     = ST_W'(1) << 0,
		S_CLEAR    = ST_W'(1) << 1,
		S_LOAD     = ST_W'(1) << 2,
		S_TOK_RD   = ST_W'(1) << 3,
		S_TOK_USE  = ST_W'(1) << 4,
		S_RMW_RD   = ST_W'(1) << 5,
		S_RMW_WR   = ST_W'(1) << 6,
		S_SWP_RD   = ST_W'(1) << 7,
		S_SWP_FACT = ST_W'(1) << 8,
		S_MUL_LO   = ST_W'(1) << 9,
		S_MUL_HI   = ST_W'(1) << 10,
		S_DIV_GO   = ST_W'(1) << 11,
		S_DIV_WAIT = ST_W'(1) << 12,
		S_ACC      = ST_W'(1) << 13,
		S_THR_LO   = ST_W'(1) << 14,
		S_THR_HI   = ST_W'(1) << 15,
		S_THR_SUM  = ST_W'(1) << 16,
		S_SRCH_RD  = ST_W'(1) << 17,
		S_SRCH_CMP = ST_W'(1) << 18,
		S_NEW      = ST_W'(1) << 19,
		S_MAJ      = ST_W'(1) << 20,
		S_FIN      = ST_W'(1) << 21,
		S_MAJ_RD   = ST_W'(1) << 22
	} state_t;

	state_t           state_q, state_d;
	logic [CMD_W-1:0] cmd_q;
	logic             rm_q, rm_d;
	logic             item_q, item_d;

	always_comb begin
		state_d = state_q;
		rm_d    = rm_q;
		item_d  = item_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					unique case (command) inside
						CMD_LOAD_COUNT, CMD_LOAD_TOTAL: state_d = S_LOAD;
						CMD_PLACE:    state_d = S_NEW;
						CMD_RESAMPLE: state_d = S_TOK_RD;
						CMD_CLEAR: begin
							item_d  = 1'b1;
							state_d = S_CLEAR;
						end
						CMD_MAJORITY: state_d = S_MAJ_RD;
						default:      state_d = S_FIN;
					endcase
				end
			end
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					item_d  = 1'b0;
					state_d = item_q ? S_FIN : S_IDLE;
				end
			end
			S_LOAD: begin
				cmd.load_cnt = (cmd_q == CMD_LOAD_COUNT);
				cmd.load_tot = (cmd_q == CMD_LOAD_TOTAL);
				state_d      = S_FIN;
			end
			S_TOK_RD: state_d = S_TOK_USE;
			S_TOK_USE: begin
				cmd.tsel_prev = 1'b1;
				rm_d          = 1'b1;
				state_d       = S_RMW_RD;
			end
			S_RMW_RD: begin
				cmd.rmw_rd = 1'b1;
				state_d    = S_RMW_WR;
			end
			S_RMW_WR: begin
				cmd.rmw_wr  = 1'b1;
				cmd.rmw_inc = !rm_q;
				state_d     = rm_q ? S_SWP_RD : S_FIN;
			end
			S_SWP_RD: state_d = S_SWP_FACT;
			S_SWP_FACT: begin
				cmd.fact = 1'b1;
				state_d  = S_MUL_LO;
			end
			S_MUL_LO: begin
				cmd.mul_lo = 1'b1;
				state_d    = S_MUL_HI;
			end
			S_MUL_HI: begin
				cmd.mul_hi = 1'b1;
				state_d    = S_DIV_GO;
			end
			S_DIV_GO: begin
				cmd.div_go = 1'b1;
				state_d    = S_DIV_WAIT;
			end
			S_DIV_WAIT: begin
				if (stat.div_done) begin
					state_d = S_ACC;
				end
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				state_d = stat.k_last ? S_THR_LO : S_SWP_RD;
			end
			S_THR_LO: begin
				cmd.thr_lo = 1'b1;
				state_d    = S_THR_HI;
			end
			S_THR_HI: begin
				cmd.thr_hi = 1'b1;
				state_d    = S_THR_SUM;
			end
			S_THR_SUM: begin
				cmd.thr_sum = 1'b1;
				state_d     = S_SRCH_RD;
			end
			S_SRCH_RD: state_d = S_SRCH_CMP;
			S_SRCH_CMP: begin
				cmd.srch_cmp = 1'b1;
				state_d      = stat.found ? S_NEW : S_SRCH_RD;
			end
			S_NEW: begin
				cmd.new_from_res = (cmd_q == CMD_RESAMPLE);
				cmd.tsel_new     = 1'b1;
				cmd.tok_wr       = 1'b1;
				rm_d             = 1'b0;
				state_d          = S_RMW_RD;
			end
			S_MAJ_RD: state_d = S_MAJ;
			S_MAJ: begin
				cmd.maj_step = 1'b1;
				state_d      = stat.k_last ? S_FIN : S_MAJ_RD;
			end
			S_FIN: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// reset starts with a sweep of the word/topic test store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cmd_q   <= '0;
			rm_q    <= 1'b0;
			item_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			rm_q    <= rm_d;
			item_q  <= item_d;
			if (cmd.capture) begin
				cmd_q <= command;
			end
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_FIN);

`ifndef SYNTHESIS
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	a_div_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV_WAIT && stat.div_done) |=> (state_q == S_ACC))
		else $error("divider result not accumulated");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (!done && !busy))
		else $error("done strobe longer than one cycle");
`endif

endmodule

`default_nettype wire

[rtl/lda_gibbs_topic_resampler.sv]
// Top level of the held-out collapsed Gibbs topic resampler.
//
// Usage: present command and its fields with start high while busy is low; the
// item is taken at that edge. Exactly one result per item appears on
// result_topic, previous_topic and saturated during the single cycle that done
// is high; the receiver cannot stall and must take it then.
// Configuration (alpha, beta, vbeta) is written by the user through cfg_valid/
// cfg_index/cfg_data while the block is idle; the block does not enforce this.
// cfg_ready is always high. In a resample each topic weight passes through the
// radix-2 divider, which retires one quotient bit per cycle over 48 bits; a
// weight whose quotient saturates or whose divisor is zero skips the bit-by-bit
// divide. The block works on one item at a time.
// Reset: an asynchronous reset restores the priors and starts a sweep of all
// word/topic entries that zeroes the word/topic test counts, document counts and
// test totals; busy stays high until it ends. Trained counts and token topics
// are not cleared.
`default_nettype none

module lda_gibbs_topic_resampler (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	output logic                            done,
	input  logic [lgtr_pkg::CMD_W-1:0]      command,
	input  logic [lgtr_pkg::WORD_W-1:0]     word,
	input  logic [lgtr_pkg::TOPIC_W-1:0]    topic,
	input  logic [lgtr_pkg::POS_W-1:0]      position,
	input  logic [lgtr_pkg::CNTV_W-1:0]     count_value,
	input  logic [lgtr_pkg::RND_W-1:0]      random_fraction,
	output logic [lgtr_pkg::TOPIC_W-1:0]    result_topic,
	output logic [lgtr_pkg::TOPIC_W-1:0]    previous_topic,
	output logic                            saturated,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lgtr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lgtr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lgtr_pkg::*;

	lgtr_cmd_t  cmd;
	lgtr_stat_t stat;

	assign cfg_ready = 1'b1;

	lgtr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .command(command),
		.stat(stat), .cmd(cmd), .busy(busy), .done(done)
	);

	lgtr_dpath u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.word(word), .topic(topic), .position(position),
		.count_value(count_value), .random_fraction(random_fraction),
		.cfg_wr(cfg_valid & cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.result_topic(result_topic), .previous_topic(previous_topic),
		.saturated(saturated)
	);

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 100ps
// Gibbs topic resampler self-checking bench: directed table, then random mix of every command but clear.
module testbench;
	import lgtr_pkg::*;

	localparam logic [CMD_W-1:0] CMD_BAD_LO = 3'd6;
	localparam logic [CMD_W-1:0] CMD_BAD_HI = 3'd7;
	localparam int WATCHDOG_LIMIT = 1500000;
	localparam int POOL_WORDS = 4;

	typedef struct {
		logic [CMD_W-1:0]   cmd;
		logic [WORD_W-1:0]  word;
		logic [TOPIC_W-1:0] topic;
		logic [POS_W-1:0]   pos;
		logic [CNTV_W-1:0]  cnt;
		logic [RND_W-1:0]   rnd;
		bit                 fixed;
		logic [TOPIC_W-1:0] res;
		logic [TOPIC_W-1:0] prev;
		logic               sat;
	} step_t;

	typedef struct {
		logic [TOPIC_W-1:0] res;
		logic [TOPIC_W-1:0] prev;
		logic               sat;
	} topic_result_t;

	logic clk, arst_n, start, busy, done;
	logic [CMD_W-1:0] command;
	logic [WORD_W-1:0] word;
	logic [TOPIC_W-1:0] topic;
	logic [POS_W-1:0] position;
	logic [CNTV_W-1:0] count_value;
	logic [RND_W-1:0] random_fraction;
	logic [TOPIC_W-1:0] result_topic, previous_topic;
	logic saturated;
	logic cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	lda_gibbs_topic_resampler dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.command(command), .word(word), .topic(topic), .position(position),
		.count_value(count_value), .random_fraction(random_fraction),
		.result_topic(result_topic), .previous_topic(previous_topic),
		.saturated(saturated), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// mirror of the sampler state
	logic [PRIOR_W-1:0] alpha_m, beta_m;
	logic [VBETA_W-1:0] vbeta_m;
	logic [COUNT_BITS-1:0] trained_cnt [int];
	logic [TEST_W-1:0] test_cnt [int];
	logic [TOTAL_W-1:0] trained_tot [TOPICS];
	logic [TEST_W-1:0] doc_cnt [TOPICS];
	logic [TEST_W-1:0] test_tot [TOPICS];
	logic [TOPIC_W-1:0] token_topic [DOC_TOKENS];
	bit placed [DOC_TOKENS];
	int placed_pos [$];
	bit bound_hit;

	topic_result_t expected_results [$];
	int failures;
	int idle_pct;
	int quiet_cycles;
	logic [WORD_W-1:0] pool [POOL_WORDS];

	function automatic logic [TEST_W-1:0] bump_up(logic [TEST_W-1:0] v);
		if (v == TEST_MAX) begin
			bound_hit = 1'b1;
			return v;
		end
		return v + 1'b1;
	endfunction

	function automatic logic [TEST_W-1:0] bump_down(logic [TEST_W-1:0] v);
		if (v == '0) begin
			bound_hit = 1'b1;
			return v;
		end
		return v - 1'b1;
	endfunction

	function automatic void add_tok(int w, int k);
		int idx;
		idx = w * TOPICS + k;
		test_cnt[idx] = bump_up(test_cnt.exists(idx) ? test_cnt[idx] : '0);
		doc_cnt[k] = bump_up(doc_cnt[k]);
		test_tot[k] = bump_up(test_tot[k]);
	endfunction

	function automatic void remove_tok(int w, int k);
		int idx;
		idx = w * TOPICS + k;
		test_cnt[idx] = bump_down(test_cnt.exists(idx) ? test_cnt[idx] : '0);
		doc_cnt[k] = bump_down(doc_cnt[k]);
		test_tot[k] = bump_down(test_tot[k]);
	endfunction

	function automatic logic [TOPIC_W-1:0] draw_topic(int w, logic [RND_W-1:0] rnd);
		logic [127:0] a, b, d, q, thr, acc;
		logic [WGT_W-1:0] wt, sum;
		logic [WGT_W-1:0] cum [TOPICS];
		int idx;
		sum = '0;
		for (int k = 0; k < TOPICS; k++) begin
			idx = w * TOPICS + k;
			a = (128'(doc_cnt[k]) << 16) + 128'(alpha_m);
			b = ((128'(trained_cnt.exists(idx) ? trained_cnt[idx] : '0) +
				128'(test_cnt.exists(idx) ? test_cnt[idx] : '0)) << 16) + 128'(beta_m);
			d = ((128'(trained_tot[k]) + 128'(test_tot[k])) << 16) + 128'(vbeta_m);
			if (d == 0) begin
				wt = WGT_MAX;
			end else begin
				q = (a * b) / d;
				wt = (q > 128'(WGT_MAX)) ? WGT_MAX : q[WGT_W-1:0];
			end
			acc = 128'(sum) + 128'(wt);
			sum = (acc > 128'(WGT_MAX)) ? WGT_MAX : acc[WGT_W-1:0];
			cum[k] = sum;
		end
		if (sum == '0)
			return '0;
		thr = (128'(rnd) * 128'(sum)) >> 32;
		for (int k = 0; k < TOPICS; k++)
			if (128'(cum[k]) >= thr)
				return TOPIC_W'(k);
		return TOPIC_W'(TOPICS - 1);
	endfunction

	function automatic topic_result_t predict_topic(step_t s);
		topic_result_t r;
		logic [CNTV_W-1:0] c;
		r = '{res: '0, prev: '0, sat: 1'b0};
		bound_hit = 1'b0;
		case (s.cmd)
			CMD_LOAD_COUNT: begin
				c = s.cnt;
				if (c > CNTV_W'(COUNT_MAX)) begin
					c = CNTV_W'(COUNT_MAX);
					bound_hit = 1'b1;
				end
				trained_cnt[s.word * TOPICS + s.topic] = c[COUNT_BITS-1:0];
			end
			CMD_LOAD_TOTAL: trained_tot[s.topic] = s.cnt;
			CMD_PLACE: begin
				token_topic[s.pos] = s.topic;
				add_tok(s.word, s.topic);
			end
			CMD_RESAMPLE: begin
				r.prev = token_topic[s.pos];
				remove_tok(s.word, r.prev);
				r.res = draw_topic(s.word, s.rnd);
				add_tok(s.word, r.res);
				token_topic[s.pos] = r.res;
			end
			CMD_CLEAR: begin
				test_cnt.delete();
				for (int k = 0; k < TOPICS; k++) begin
					doc_cnt[k] = '0;
					test_tot[k] = '0;
				end
			end
			CMD_MAJORITY: begin
				for (int k = 1; k < TOPICS; k++)
					if (doc_cnt[k] > doc_cnt[r.res])
						r.res = TOPIC_W'(k);
			end
			default: ;
		endcase
		r.sat = bound_hit;
		return r;
	endfunction

	// hold start until the item is taken, then maybe idle
	task automatic issue(step_t s);
		topic_result_t r;
		start <= 1'b1;
		command <= s.cmd;
		word <= s.word;
		topic <= s.topic;
		position <= s.pos;
		count_value <= s.cnt;
		random_fraction <= s.rnd;
		do @(posedge clk); while (busy !== 1'b0);
		r = predict_topic(s);
		if (s.fixed)
			r = '{res: s.res, prev: s.prev, sat: s.sat};
		expected_results = {expected_results, r};
		if (s.cmd == CMD_PLACE && !placed[s.pos]) begin
			placed[s.pos] = 1'b1;
			placed_pos = {placed_pos, int'(s.pos)};
		end
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0 || busy !== 1'b0);
	endtask

	task automatic configure(logic [PRIOR_W-1:0] al, logic [PRIOR_W-1:0] be,
			logic [VBETA_W-1:0] vb);
		logic [CFG_DATA_W-1:0] vals [3];
		logic [CFG_IDX_W-1:0] idxs [3];
		vals = '{CFG_DATA_W'(al), CFG_DATA_W'(be), vb};
		idxs = '{CFG_ALPHA, CFG_BETA, CFG_VBETA};
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idxs[i];
			cfg_data <= vals[i];
			do @(posedge clk); while (cfg_ready !== 1'b1);
		end
		cfg_valid <= 1'b0;
		alpha_m = al;
		beta_m = be;
		vbeta_m = vb;
	endtask

	function automatic step_t mk(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] w,
			logic [TOPIC_W-1:0] t, logic [POS_W-1:0] p, logic [CNTV_W-1:0] c,
			logic [RND_W-1:0] rnd, bit fixed, logic [TOPIC_W-1:0] res, logic sat);
		return '{cmd: cmd, word: w, topic: t, pos: p, cnt: c, rnd: rnd, fixed: fixed,
			res: res, prev: '0, sat: sat};
	endfunction

	function automatic step_t random_step();
		int r;
		step_t s;
		r = $urandom_range(99);
		s = mk(CMD_PLACE, pool[$urandom_range(POOL_WORDS-1)], $urandom_range(TOPICS-1),
			$urandom_range(DOC_TOKENS-1), $urandom, $urandom, 0, '0, 0);
		if (r < 35 && placed_pos.size() != 0) begin
			s.cmd = CMD_RESAMPLE;
			s.pos = placed_pos[$urandom_range(placed_pos.size()-1)];
		end else if (r < 65) begin
			if ($urandom_range(4) == 0)
				s.word = $urandom;
		end else if (r < 75) begin
			s.cmd = CMD_LOAD_COUNT;
			s.cnt = ($urandom_range(3) == 0) ? CNTV_W'($urandom) :
				CNTV_W'($urandom_range(int'(COUNT_MAX)));
		end else if (r < 82) begin
			s.cmd = CMD_LOAD_TOTAL;
			if ($urandom_range(7) == 0)
				s.cnt = '0;
		end else if (r < 92) begin
			s.cmd = CMD_MAJORITY;
		end else begin
			s.cmd = $urandom_range(1) ? CMD_BAD_HI : CMD_BAD_LO;
			s.word = $urandom;
		end
		return s;
	endfunction

	task automatic random_phase(int n);
		for (int i = 0; i < n; i++)
			issue(random_step());
	endtask

	always @(posedge clk) begin
		topic_result_t e;
		if (arst_n && done === 1'b1) begin
			if (expected_results.size() == 0) begin
				$error("result_topic=%0d with no item pending", result_topic);
				failures++;
			end else begin
				e = expected_results.pop_front();
				if (result_topic !== e.res) begin
					$error("result_topic: expected %0d, got %0d", e.res, result_topic);
					failures++;
				end
				if (previous_topic !== e.prev) begin
					$error("previous_topic: expected %0d, got %0d", e.prev, previous_topic);
					failures++;
				end
				if (saturated !== e.sat) begin
					$error("saturated: expected %0d, got %0d", e.sat, saturated);
					failures++;
				end
			end
		end
	end

	// watchdog: cycles with no item taken and no result
	always @(posedge clk) begin
		if (done === 1'b1 || (start === 1'b1 && busy === 1'b0))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[lda_gibbs_topic_resampler] ERROR");
			$finish;
		end
	end

	initial begin
		step_t directed [$];
		failures = 0;
		quiet_cycles = 0;
		idle_pct = 30;
		arst_n = 1'b0;
		start = 1'b0;
		command = '0;
		word = '0;
		topic = '0;
		position = '0;
		count_value = '0;
		random_fraction = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		alpha_m = ALPHA_RST;
		beta_m = BETA_RST;
		vbeta_m = VBETA_RST;
		for (int k = 0; k < TOPICS; k++) begin
			trained_tot[k] = '0;
			doc_cnt[k] = '0;
			test_tot[k] = '0;
		end
		for (int p = 0; p < DOC_TOKENS; p++) begin
			token_topic[p] = '0;
			placed[p] = 1'b0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		directed = {directed, mk(CMD_BAD_HI, '1, '1, '1, '1, '1, 1, '0, 0)};
		directed = {directed, mk(CMD_BAD_LO, '0, '0, '0, '0, '0, 1, '0, 0)};
		directed = {directed, mk(CMD_LOAD_COUNT, '1, '1, '0, '1, '0, 1, '0, 1)};
		directed = {directed, mk(CMD_LOAD_COUNT, '0, '0, '0, 24'h0FFFFF, '0, 1, '0, 0)};
		directed = {directed, mk(CMD_LOAD_COUNT, '0, 6'd1, '0, 24'h100000, '0, 1, '0, 1)};
		directed = {directed, mk(CMD_LOAD_TOTAL, '0, '0, '0, '0, '0, 1, '0, 0)};
		directed = {directed, mk(CMD_LOAD_TOTAL, '0, '1, '0, '1, '0, 1, '0, 0)};
		directed = {directed, mk(CMD_MAJORITY, '0, '0, '0, '0, '0, 1, '0, 0)};
		directed = {directed, mk(CMD_PLACE, '0, '1, '1, '0, '0, 1, '0, 0)};
		directed = {directed, mk(CMD_PLACE, '1, '0, '0, '0, '1, 1, '0, 0)};
		// same position placed twice with the same topic adds it to the counts twice
		directed = {directed, mk(CMD_PLACE, '0, '1, '1, '0, '0, 1, '0, 0)};
		directed = {directed, mk(CMD_MAJORITY, '0, '0, '0, '0, '0, 0, '0, 0)};
		directed = {directed, mk(CMD_CLEAR, '1, '1, '1, '1, '1, 1, '0, 0)};
		directed = {directed, mk(CMD_MAJORITY, '0, '0, '0, '0, '0, 1, '0, 0)};
		foreach (directed[i])
			issue(directed[i]);

		// load every topic of a few words so resampling reads only written entries
		for (int i = 0; i < POOL_WORDS; i++) begin
			pool[i] = $urandom;
			for (int k = 0; k < TOPICS; k++)
				issue(mk(CMD_LOAD_COUNT, pool[i], k, $urandom, $urandom_range(2000),
					$urandom, 0, '0, 0));
		end
		for (int k = 0; k < TOPICS; k++)
			issue(mk(CMD_LOAD_TOTAL, $urandom, k, $urandom,
				($urandom_range(7) == 0) ? '0 : CNTV_W'($urandom), $urandom, 0, '0, 0));
		random_phase(100);
		drain();

		// zero priors: after a clear, removals stick at zero and resamples see an empty sum while doc counts are zero
		configure('0, '0, 32'd1);
		issue(mk(CMD_CLEAR, '0, '0, '0, '0, '0, 1, '0, 0));
		random_phase(120);
		drain();

		idle_pct = 61;
		configure('1, '1, '0);
		random_phase(110);
		drain();

		configure($urandom, $urandom, '1);
		random_phase(110);
		drain();

		idle_pct = 0;
		configure(ALPHA_RST, BETA_RST, VBETA_RST);
		random_phase(110);
		drain();

		repeat (20) @(posedge clk);
		if (failures == 0)
			$display("[lda_gibbs_topic_resampler] OK");
		else
			$display("[lda_gibbs_topic_resampler] ERROR");
		$finish;
	end
endmodule
